>>> hw/rtl/ecpr_pkg.sv
// Package for the enhanced clock page replacement block.
// Action, status and state codes plus the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package ecpr_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_ACCESS = 2'd1,
        ACT_EVICT  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_ACC_SCAN,
        S_EV_SCAN,
        S_EV_VIC,
        S_EV_REM,
        S_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic ins_shift;
        logic acc_issue;
        logic ev_scan;
        logic ev_vic;
        logic ev_rem;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic ins_last;
        logic acc_more;
        logic ev_pick;
        logic ev_vic_last;
        logic ev_rem_last;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/ecpr_ctrl.sv
// Sequencing controller for the clock replacement block.
// Depends on ecpr_pkg; drives commands to ecpr_dp.
`timescale 1ns / 1ps

module ecpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ecpr_pkg::t_action i_action,
    input  ecpr_pkg::t_stat   i_stat,
    output ecpr_pkg::t_cmd    o_cmd
);
    import ecpr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    unique case (i_action)
                        ACT_INSERT: n_state = i_stat.full ? S_FIN : S_INS_SHIFT;
                        ACT_ACCESS: n_state = S_ACC_SCAN;
                        ACT_EVICT:  n_state = i_stat.empty ? S_FIN : S_EV_SCAN;
                        ACT_NOP:    n_state = S_FIN;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_INS_SHIFT: begin
                o_cmd.ins_shift = 1'b1;
                if (i_stat.ins_last) begin
                    n_state = S_FIN;
                end
            end
            S_ACC_SCAN: begin
                if (i_stat.acc_more) begin
                    o_cmd.acc_issue = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_EV_SCAN: begin
                o_cmd.ev_scan = 1'b1;
                if (i_stat.ev_pick) begin
                    n_state = S_EV_VIC;
                end
            end
            S_EV_VIC: begin
                o_cmd.ev_vic = 1'b1;
                n_state = i_stat.ev_vic_last ? S_FIN : S_EV_REM;
            end
            S_EV_REM: begin
                o_cmd.ev_rem = 1'b1;
                if (i_stat.ev_rem_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a transfer is only taken while idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> r_state == S_IDLE)
        else $error("start outside idle");

    // one command at a time
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("overlapping datapath commands");

    // after finishing, the block is ready for the next transfer
    a_fin_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_in_ready)
        else $error("not ready after finish");

endmodule

>>> hw/rtl/ecpr_dp.sv
// Datapath for the clock replacement block: page memory, flag vectors,
// count, hand, scan pointers and output register. Depends on ecpr_pkg.
`timescale 1ns / 1ps

module ecpr_dp #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ecpr_pkg::t_cmd        i_cmd,
    output ecpr_pkg::t_stat       o_stat,
    input  ecpr_pkg::t_action     i_action,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic                  i_write,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PAGE_BITS-1:0]  o_victim,
    output ecpr_pkg::t_status     o_status
);
    import ecpr_pkg::*;

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    logic [PAGE_BITS-1:0]  mem [NUM_FRAMES];
    logic [PAGE_BITS-1:0]  r_rdata;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [IW-1:0]         mem_raddr;
    logic [PAGE_BITS-1:0]  mem_wdata;

    logic [NUM_FRAMES-1:0] r_acc;
    logic [NUM_FRAMES-1:0] r_drt;
    logic [NUM_FRAMES-1:0] r_shd;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_hand;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_widx;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_cmp_v;
    logic                  r_hit;
    logic [PAGE_BITS-1:0]  r_carry;
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_wr;
    t_action               r_op;
    t_status               r_status;
    logic [PAGE_BITS-1:0]  r_victim;
    logic                  r_out_valid;
    logic [PAGE_BITS-1:0]  r_out_victim;
    t_status               r_out_status;

    logic [CW:0]           idx_p1;
    logic [CW:0]           widx_p1;
    logic [CW:0]           widx_p2;
    logic [IW-1:0]         hidx;
    logic                  match;
    logic                  out_free;
    logic [CW-1:0]         idx_wrap;

    function automatic logic [NUM_FRAMES-1:0] f_ins(input logic [NUM_FRAMES-1:0] v,
                                                    input logic [CW-1:0] h);
        logic [NUM_FRAMES-1:0] r;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (i > int'(h)) begin
                r[i] = v[i-1];
            end else if (i == int'(h)) begin
                r[i] = 1'b0;
            end else begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

    function automatic logic [NUM_FRAMES-1:0] f_rem(input logic [NUM_FRAMES-1:0] v,
                                                    input logic [CW-1:0] h);
        logic [NUM_FRAMES-1:0] r;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (i >= int'(h)) begin
                r[i] = (i + 1 < NUM_FRAMES) ? v[(i+1) % NUM_FRAMES] : 1'b0;
            end else begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

    assign idx_p1   = {1'b0, r_idx} + (CW+1)'(1);
    assign widx_p1  = {1'b0, r_widx} + (CW+1)'(1);
    assign widx_p2  = {1'b0, r_widx} + (CW+1)'(2);
    assign hidx     = r_idx[IW-1:0];
    assign idx_wrap = (idx_p1 >= {1'b0, r_count}) ? '0 : idx_p1[CW-1:0];
    assign match    = r_cmp_v && (r_rdata == r_page);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.full        = (r_count == CW'(NUM_FRAMES));
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.ins_last    = (r_widx == r_count);
    assign o_stat.acc_more    = (r_idx < r_count);
    assign o_stat.ev_pick     = !r_acc[hidx] && !r_shd[hidx];
    assign o_stat.ev_vic_last = (idx_p1 == {1'b0, r_count});
    assign o_stat.ev_rem_last = (widx_p2 == {1'b0, r_count});
    assign o_stat.out_free    = out_free;

    assign o_out_valid = r_out_valid;
    assign o_victim    = r_out_victim;
    assign o_status    = r_out_status;

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_widx[IW-1:0];
        mem_wdata = r_carry;
        mem_raddr = hidx;
        if (i_cmd.start) begin
            mem_raddr = r_hand[IW-1:0];
        end else if (i_cmd.ins_shift) begin
            mem_we    = 1'b1;
            mem_raddr = widx_p1[IW-1:0];
        end else if (i_cmd.ev_vic) begin
            mem_raddr = idx_p1[IW-1:0];
        end else if (i_cmd.ev_rem) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata;
            mem_raddr = widx_p2[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_drt       <= '0;
            r_shd       <= '0;
            r_count     <= '0;
            r_hand      <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.acc_issue;
            if (match) begin
                r_acc[r_cmp_idx] <= 1'b1;
                if (r_wr) begin
                    r_drt[r_cmp_idx] <= 1'b1;
                end
            end
            if (i_cmd.start && i_action == ACT_EVICT) begin
                r_shd <= r_drt;
            end
            if (i_cmd.ev_scan && !o_stat.ev_pick) begin
                if (r_acc[hidx]) begin
                    r_acc[hidx] <= 1'b0;
                end else begin
                    r_shd[hidx] <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_status == ST_OK && r_op == ACT_INSERT) begin
                    r_acc   <= f_ins(r_acc, r_hand);
                    r_drt   <= f_ins(r_drt, r_hand);
                    r_shd   <= f_ins(r_shd, r_hand);
                    r_count <= r_count + CW'(1);
                    r_hand  <= r_hand + CW'(1);
                end else if (r_status == ST_OK && r_op == ACT_EVICT) begin
                    r_acc   <= f_rem(r_acc, r_idx);
                    r_drt   <= f_rem(r_drt, r_idx);
                    r_shd   <= f_rem(r_shd, r_idx);
                    r_count <= r_count - CW'(1);
                    r_hand  <= r_idx;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (match) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.start) begin
            r_op     <= i_action;
            r_page   <= i_page;
            r_wr     <= i_write;
            r_victim <= '0;
            r_hit    <= 1'b0;
            r_carry  <= i_page;
            r_widx   <= r_hand;
            r_idx    <= (i_action == ACT_EVICT && r_hand != r_count) ? r_hand : '0;
            if (i_action == ACT_INSERT && o_stat.full) begin
                r_status <= ST_FULL;
            end else if (i_action == ACT_EVICT && o_stat.empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.ins_shift) begin
            r_carry <= r_rdata;
            r_widx  <= widx_p1[CW-1:0];
        end
        if (i_cmd.acc_issue) begin
            r_cmp_idx <= hidx;
            r_idx     <= idx_p1[CW-1:0];
        end
        if (i_cmd.ev_scan && !o_stat.ev_pick) begin
            r_idx <= idx_wrap;
        end
        if (i_cmd.ev_vic) begin
            r_victim <= r_rdata;
            r_widx   <= r_idx;
        end
        if (i_cmd.ev_rem) begin
            r_widx <= widx_p1[CW-1:0];
        end
        if (i_cmd.finish) begin
            r_out_victim <= r_victim;
            r_out_status <= (r_op == ACT_ACCESS && !r_hit) ? ST_MISS : r_status;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_FRAMES))
        else $error("entry count out of range");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= r_count)
        else $error("hand beyond ring");

    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_acc | r_drt | r_shd) >> r_count) == '0)
        else $error("flags set on unused entry");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_op == ACT_INSERT && r_status == ST_OK
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow ring");

endmodule

>>> hw/rtl/enhanced_clock_page_replacement.sv
// Top level of the enhanced second-chance clock page replacement block.
// Instantiates ecpr_ctrl and ecpr_dp; depends on ecpr_pkg.
//
// channel  dir  fields (tdata, low bit first)
// s_axis   in   action[1:0], page_number[PAGE_BITS], is_write[1]
// m_axis   out  victim_page[PAGE_BITS], status[2]
//
// One item at a time; one result per item, held in an output register.
// Insert: page memory shifted one entry a cycle.
// Access: one stored page compared a cycle.
// Evict: a scan for the victim, then a removal shift of the entries behind it
//        (no shift when the victim is the last entry).
// Reset (i_rst_n low, synchronous) empties the ring; a stalled result holds the next item at its finish.
`timescale 1ns / 1ps

module enhanced_clock_page_replacement #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 20,
    localparam int IN_W  = ((PAGE_BITS + 3 + 7) / 8) * 8,
    localparam int OUT_W = ((PAGE_BITS + 2 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // action, page_number, is_write
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // victim_page, status
    output logic [OUT_W-1:0] m_axis_tdata
);
    import ecpr_pkg::*;

    t_cmd                 cmd;
    t_stat                stat;
    t_action              action;
    t_status              status;
    logic [PAGE_BITS-1:0] victim;

    assign action = t_action'(s_axis_tdata[1:0]);

    ecpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_action   (action),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ecpr_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (action),
        .i_page      (s_axis_tdata[PAGE_BITS+1:2]),
        .i_write     (s_axis_tdata[PAGE_BITS+2]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_victim    (victim),
        .o_status    (status)
    );

    assign m_axis_tdata = OUT_W'({status, victim});

endmodule
